// ===== src/vn3_pkg.sv =====
// vn3_pkg: shared constant for the 3d vector normalizer
`timescale 1ns / 1ps
`default_nettype none
package vn3_pkg;
    localparam int FIELD_W = 32;
endpackage
`default_nettype wire

// ===== src/vn3_vec_if.sv =====
// vn3_vec_if: valid/ready channel carrying one input vector
`timescale 1ns / 1ps
`default_nettype none
interface vn3_vec_if
    import vn3_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] comp_x;
    logic [FIELD_W-1:0] comp_y;
    logic [FIELD_W-1:0] comp_z;

    modport source (output valid, comp_x, comp_y, comp_z, input ready);
    modport sink (input valid, comp_x, comp_y, comp_z, output ready);
endinterface
`default_nettype wire

// ===== src/vn3_unit_if.sv =====
// vn3_unit_if: valid/ready channel carrying one normalized vector
`timescale 1ns / 1ps
`default_nettype none
interface vn3_unit_if
    import vn3_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] unit_x;
    logic [FIELD_W-1:0] unit_y;
    logic [FIELD_W-1:0] unit_z;
    logic [FIELD_W-1:0] vec_length;
    logic               zero_flag;

    modport source (output valid, unit_x, unit_y, unit_z, vec_length, zero_flag,
                    input ready);
    modport sink (input valid, unit_x, unit_y, unit_z, vec_length, zero_flag,
                  output ready);
endinterface
`default_nettype wire

// ===== src/vn3_square.sv =====
// vn3_square: magnitude split, squaring and sum of squares, three stages
`timescale 1ns / 1ps
`default_nettype none
module vn3_square
    import vn3_pkg::*;
#(
    parameter int W = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               adv,
    input  wire logic               in_valid,
    input  wire logic [FIELD_W-1:0] comp_x,
    input  wire logic [FIELD_W-1:0] comp_y,
    input  wire logic [FIELD_W-1:0] comp_z,
    output logic                    sum_valid,
    output logic [2*W-1:0]          sum,
    output logic [3*W+2:0]          side
);
    logic [W-1:0]   raw_x, raw_y, raw_z;
    logic [W-1:0]   mag_x_next, mag_y_next, mag_z_next;
    logic [W-1:0]   mag_x_reg, mag_y_reg, mag_z_reg;
    logic [2:0]     neg_reg;
    logic           vld0_reg, vld1_reg, vld2_reg;
    logic [2*W-1:0] sq_x_reg, sq_y_reg, sq_z_reg;
    logic [3*W+2:0] side1_reg, side2_reg;
    logic [2*W-1:0] sum_reg;

    assign raw_x = comp_x[W-1:0];
    assign raw_y = comp_y[W-1:0];
    assign raw_z = comp_z[W-1:0];
    assign mag_x_next = raw_x[W-1] ? (~raw_x + 1'b1) : raw_x;
    assign mag_y_next = raw_y[W-1] ? (~raw_y + 1'b1) : raw_y;
    assign mag_z_next = raw_z[W-1] ? (~raw_z + 1'b1) : raw_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld0_reg <= in_valid;
            vld1_reg <= vld0_reg;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_x_reg <= mag_x_next;
            mag_y_reg <= mag_y_next;
            mag_z_reg <= mag_z_next;
            neg_reg   <= {raw_x[W-1], raw_y[W-1], raw_z[W-1]};
            sq_x_reg  <= mag_x_reg * mag_x_reg;
            sq_y_reg  <= mag_y_reg * mag_y_reg;
            sq_z_reg  <= mag_z_reg * mag_z_reg;
            side1_reg <= {neg_reg, mag_x_reg, mag_y_reg, mag_z_reg};
            sum_reg   <= sq_x_reg + sq_y_reg + sq_z_reg;
            side2_reg <= side1_reg;
        end
    end

    assign sum_valid = vld2_reg;
    assign sum       = sum_reg;
    assign side      = side2_reg;
endmodule
`default_nettype wire

// ===== src/vn3_root.sv =====
// vn3_root: pipelined floor square root, one result bit per stage
`timescale 1ns / 1ps
`default_nettype none
module vn3_root #(
    parameter int W      = 32,
    parameter int SIDE_W = 99
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              in_valid,
    input  wire logic [2*W-1:0]    radicand,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   root_valid,
    output logic [W-1:0]           root,
    output logic [SIDE_W-1:0]      side_out
);
    logic [2*W-1:0]    rad_reg  [W];
    logic [W+1:0]      rem_reg  [W];
    logic [W-1:0]      root_reg [W];
    logic [SIDE_W-1:0] side_reg [W];
    logic              vld_reg  [W];

    for (genvar k = 0; k < W; k++)
    begin : g_stage
        logic [2*W-1:0]    rad_cur;
        logic [W+1:0]      rem_cur;
        logic [W-1:0]      root_cur;
        logic [SIDE_W-1:0] side_cur;
        logic              vld_cur;
        logic [W+1:0]      rem_sh;
        logic [W+1:0]      trial;
        logic              take;
        logic [W+1:0]      rem_next;
        logic [W-1:0]      root_next;

        if (k == 0)
        begin : g_first
            assign rad_cur  = radicand;
            assign rem_cur  = '0;
            assign root_cur = '0;
            assign side_cur = side_in;
            assign vld_cur  = in_valid;
        end
        else
        begin : g_rest
            assign rad_cur  = rad_reg[k-1];
            assign rem_cur  = rem_reg[k-1];
            assign root_cur = root_reg[k-1];
            assign side_cur = side_reg[k-1];
            assign vld_cur  = vld_reg[k-1];
        end

        assign rem_sh    = {rem_cur[W-1:0], rad_cur[2*W-1:2*W-2]};
        assign trial     = {root_cur, 2'b01};
        assign take      = (rem_sh >= trial);
        assign rem_next  = take ? (rem_sh - trial) : rem_sh;
        assign root_next = {root_cur[W-2:0], take};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k] <= vld_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rad_reg[k]  <= {rad_cur[2*W-3:0], 2'b00};
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_cur;
            end
        end
    end

    assign root_valid = vld_reg[W-1];
    assign root       = root_reg[W-1];
    assign side_out   = side_reg[W-1];
endmodule
`default_nettype wire

// ===== src/vn3_div3.sv =====
// vn3_div3: three-lane pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module vn3_div3 #(
    parameter int W = 32,
    parameter int F = 30
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         adv,
    input  wire logic         in_valid,
    input  wire logic [W-1:0] len_in,
    input  wire logic [2:0]   neg_in,
    input  wire logic [W-1:0] mag_in [3],
    output logic              quo_valid,
    output logic [W-1:0]      len_out,
    output logic [2:0]        neg_out,
    output logic [F:0]        quo [3]
);
    localparam int S = F + 1;

    logic [W-1:0] rem_reg [S][3];
    logic [F:0]   q_reg   [S][3];
    logic [W-1:0] len_reg [S];
    logic [2:0]   neg_reg [S];
    logic         vld_reg [S];

    for (genvar j = 0; j < S; j++)
    begin : g_stage
        logic [W-1:0] len_cur;
        logic [2:0]   neg_cur;
        logic         vld_cur;
        logic [W-1:0] rem_next [3];
        logic [F:0]   q_next   [3];

        if (j == 0)
        begin : g_first
            assign len_cur = len_in;
            assign neg_cur = neg_in;
            assign vld_cur = in_valid;
        end
        else
        begin : g_rest
            assign len_cur = len_reg[j-1];
            assign neg_cur = neg_reg[j-1];
            assign vld_cur = vld_reg[j-1];
        end

        for (genvar l = 0; l < 3; l++)
        begin : g_lane
            logic [W:0] r_sh;
            logic [W:0] r_sub;
            logic       ge;
            logic [F:0] q_cur;

            if (j == 0)
            begin : g_first
                assign r_sh  = {1'b0, mag_in[l]};
                assign q_cur = '0;
            end
            else
            begin : g_rest
                assign r_sh  = {rem_reg[j-1][l], 1'b0};
                assign q_cur = q_reg[j-1][l];
            end

            assign ge          = (r_sh >= {1'b0, len_cur});
            assign r_sub       = r_sh - {1'b0, len_cur};
            assign rem_next[l] = ge ? r_sub[W-1:0] : r_sh[W-1:0];
            assign q_next[l]   = {q_cur[F-1:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[j] <= vld_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                len_reg[j] <= len_cur;
                neg_reg[j] <= neg_cur;
                rem_reg[j] <= rem_next;
                q_reg[j]   <= q_next;
            end
        end
    end

    assign quo_valid = vld_reg[S-1];
    assign len_out   = len_reg[S-1];
    assign neg_out   = neg_reg[S-1];
    assign quo       = q_reg[S-1];
endmodule
`default_nettype wire

// ===== src/vector_normalize_3d.sv =====
// vector_normalize_3d: top level of the pipelined 3d vector normalizer
// usage:
//   samples carries one vector per transfer: comp_x, comp_y, comp_z, signed
//   Q16.16 (only the low IN_WIDTH bits are read). normals carries one result
//   per transfer: unit_x/y/z in Q1.OUT_FRAC_BITS saturated to plus or minus
//   one, vec_length as the floor root of the sum of squares, and zero_flag
//   for an all-zero vector (units and length then read zero).
//   throughput: one vector per cycle while normals is not stalled with a result waiting.
//   the path runs through the magnitude, squares and sum registers, the
//   IN_WIDTH root stages, one divider stage per quotient bit
//   (OUT_FRAC_BITS + 1), and the output register.
//   reset clears every stage valid bit; no item is in flight afterward and
//   samples.ready is high.
//   when normals is stalled with a result waiting, the whole pipeline holds
//   and samples.ready drops; nothing is dropped or repeated. while the output
//   register is empty or taken in the same cycle, samples.ready stays high.
`timescale 1ns / 1ps
`default_nettype none
module vector_normalize_3d
    import vn3_pkg::*;
#(
    parameter int IN_WIDTH      = 32,
    parameter int OUT_FRAC_BITS = 30
) (
    input wire logic   clk,
    input wire logic   rst_n,
    vn3_vec_if.sink    samples,
    vn3_unit_if.source normals
);
    localparam int W      = IN_WIDTH;
    localparam int F      = OUT_FRAC_BITS;
    localparam int SIDE_W = 3 * W + 3;

    logic              adv;
    logic              sum_valid;
    logic [2*W-1:0]    sum;
    logic [SIDE_W-1:0] sq_side;
    logic              root_valid;
    logic [W-1:0]      root;
    logic [SIDE_W-1:0] root_side;
    logic [W-1:0]      mags [3];
    logic              quo_valid;
    logic [W-1:0]      len_q;
    logic [2:0]        neg_q;
    logic [F:0]        quo [3];
    logic [FIELD_W-1:0] unit_next [3];
    logic              zero_next;

    logic               out_vld_reg;
    logic [FIELD_W-1:0] unit_reg [3];
    logic [FIELD_W-1:0] len_reg;
    logic               zero_reg;

    assign adv           = !out_vld_reg || normals.ready;
    assign samples.ready = adv;

    vn3_square #(.W(W)) u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (samples.valid),
        .comp_x    (samples.comp_x),
        .comp_y    (samples.comp_y),
        .comp_z    (samples.comp_z),
        .sum_valid (sum_valid),
        .sum       (sum),
        .side      (sq_side)
    );

    vn3_root #(.W(W), .SIDE_W(SIDE_W)) u_root (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (sum_valid),
        .radicand   (sum),
        .side_in    (sq_side),
        .root_valid (root_valid),
        .root       (root),
        .side_out   (root_side)
    );

    assign mags[0] = root_side[3*W-1:2*W];
    assign mags[1] = root_side[2*W-1:W];
    assign mags[2] = root_side[W-1:0];

    vn3_div3 #(.W(W), .F(F)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (root_valid),
        .len_in    (root),
        .neg_in    (root_side[SIDE_W-1:3*W]),
        .mag_in    (mags),
        .quo_valid (quo_valid),
        .len_out   (len_q),
        .neg_out   (neg_q),
        .quo       (quo)
    );

    assign zero_next = (len_q == '0);

    for (genvar l = 0; l < 3; l++)
    begin : g_unit
        logic [F:0]         sat;
        logic [FIELD_W-1:0] ext;

        assign sat = (quo[l] > (F+1)'(1 << F)) ? (F+1)'(1 << F) : quo[l];
        assign ext = {{(FIELD_W-F-1){1'b0}}, sat};
        assign unit_next[l] = zero_next ? '0 : (neg_q[2-l] ? (~ext + 1'b1) : ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= quo_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            unit_reg <= unit_next;
            len_reg  <= FIELD_W'(len_q);
            zero_reg <= zero_next;
        end
    end

    assign normals.valid      = out_vld_reg;
    assign normals.unit_x     = unit_reg[0];
    assign normals.unit_y     = unit_reg[1];
    assign normals.unit_z     = unit_reg[2];
    assign normals.vec_length = len_reg;
    assign normals.zero_flag  = zero_reg;
endmodule
`default_nettype wire

// ===== src/vn3_checker.sv =====
// vn3_checker: port-level assertions for the normalizer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module vn3_checker
    import vn3_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [FIELD_W-1:0] unit_x,
    input wire logic [FIELD_W-1:0] unit_y,
    input wire logic [FIELD_W-1:0] unit_z,
    input wire logic [FIELD_W-1:0] vec_length,
    input wire logic               zero_flag
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_flag |->
            unit_x == '0 && unit_y == '0 && unit_z == '0 && vec_length == '0)
        else $error("zero vector with nonzero fields");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !zero_flag |-> vec_length != '0)
        else $error("zero length without zero flag");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input stalled with output free");
endmodule

bind vector_normalize_3d vn3_checker u_vn3_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (samples.ready),
    .out_valid  (normals.valid),
    .out_ready  (normals.ready),
    .unit_x     (normals.unit_x),
    .unit_y     (normals.unit_y),
    .unit_z     (normals.unit_z),
    .vec_length (normals.vec_length),
    .zero_flag  (normals.zero_flag)
);
`default_nettype wire

// ===== dv/vector_normalize_3d_tb.sv =====
// vector_normalize_3d_tb: directed and randomized check of the 3d vector normalizer against a bit-exact predictor
`timescale 1ns / 1ps
`default_nettype none

class normal_scoreboard;
    logic [31:0] exp_x[$];
    logic [31:0] exp_y[$];
    logic [31:0] exp_z[$];
    logic [31:0] exp_len[$];
    logic        exp_zero[$];
    int          errors;

    function new();
        errors = 0;
    endfunction

    static function logic [63:0] floor_sqrt(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    static function logic [31:0] unit_of(logic [31:0] c, logic [63:0] len);
        logic [63:0] mag;
        logic [63:0] q;
        mag = c[31] ? (64'd1 << 32) - {32'd0, c} : {32'd0, c};
        q   = (mag << 30) / len;
        if (q > (64'd1 << 30))
            q = 64'd1 << 30;
        if (c[31])
            q = 64'd0 - q;
        return q[31:0];
    endfunction

    function void note_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        logic [63:0] mx;
        logic [63:0] my;
        logic [63:0] mz;
        logic [63:0] len;
        mx  = x[31] ? (64'd1 << 32) - {32'd0, x} : {32'd0, x};
        my  = y[31] ? (64'd1 << 32) - {32'd0, y} : {32'd0, y};
        mz  = z[31] ? (64'd1 << 32) - {32'd0, z} : {32'd0, z};
        len = floor_sqrt(mx * mx + my * my + mz * mz);
        if (len == 0)
        begin
            exp_x.push_back(0);
            exp_y.push_back(0);
            exp_z.push_back(0);
            exp_len.push_back(0);
            exp_zero.push_back(1'b1);
        end
        else
        begin
            exp_x.push_back(unit_of(x, len));
            exp_y.push_back(unit_of(y, len));
            exp_z.push_back(unit_of(z, len));
            exp_len.push_back(len[31:0]);
            exp_zero.push_back(1'b0);
        end
    endfunction

    function int pending();
        return exp_x.size();
    endfunction
endclass

module vector_normalize_3d_tb;
    import vn3_pkg::*;

    logic clk;
    logic rst_n;
    logic hold_normals;
    int   src_idle_pct;
    int   snk_stall_pct;
    int   idle_count;
    int   timed_out;

    vn3_vec_if  samples();
    vn3_unit_if normals();

    normal_scoreboard sb;

    vector_normalize_3d i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .normals (normals)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        sb.errors++;
    endtask

    task automatic check_normal();
        if (sb.pending() == 0)
        begin
            $display("unexpected result transfer");
            sb.errors++;
            return;
        end
        if (normals.unit_x !== sb.exp_x[0])
            report_mismatch("unit_x", normals.unit_x, sb.exp_x[0]);
        if (normals.unit_y !== sb.exp_y[0])
            report_mismatch("unit_y", normals.unit_y, sb.exp_y[0]);
        if (normals.unit_z !== sb.exp_z[0])
            report_mismatch("unit_z", normals.unit_z, sb.exp_z[0]);
        if (normals.vec_length !== sb.exp_len[0])
            report_mismatch("vec_length", normals.vec_length, sb.exp_len[0]);
        if (normals.zero_flag !== sb.exp_zero[0])
            report_mismatch("zero_flag", {31'd0, normals.zero_flag}, {31'd0, sb.exp_zero[0]});
        void'(sb.exp_x.pop_front());
        void'(sb.exp_y.pop_front());
        void'(sb.exp_z.pop_front());
        void'(sb.exp_len.pop_front());
        void'(sb.exp_zero.pop_front());
    endtask

    // monitor, watchdog and receiver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (samples.valid && samples.ready)
                sb.note_vector(samples.comp_x, samples.comp_y, samples.comp_z);
            if (normals.valid && normals.ready)
                check_normal();
            if ((samples.valid && samples.ready) || (normals.valid && normals.ready))
                idle_count <= 0;
            else
                idle_count <= idle_count + 1;
            normals.ready <= !hold_normals && ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (idle_count > 5000 && timed_out == 0)
        begin
            timed_out = 1;
            $display("vector_normalize_3d verification failed");
            $finish;
        end
    end

    task automatic send_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        while ($urandom_range(99) < src_idle_pct)
        begin
            samples.valid <= 1'b0;
            @(posedge clk);
        end
        samples.valid  <= 1'b1;
        samples.comp_x <= x;
        samples.comp_y <= y;
        samples.comp_z <= z;
        @(posedge clk);
        while (!samples.ready)
            @(posedge clk);
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(255) - 128;
            2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
            3: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
            4: return 32'd0;
            default: return $signed($urandom) >>> $urandom_range(31);
        endcase
    endfunction

    task automatic drain();
        samples.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic random_phase(int count, int idle, int stall);
        src_idle_pct  = idle;
        snk_stall_pct = stall;
        repeat (count)
            send_vector(rand_comp(), rand_comp(), rand_comp());
    endtask

    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        hold_normals  = 1'b0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        idle_count    = 0;
        timed_out     = 0;
        samples.valid  = 1'b0;
        samples.comp_x = '0;
        samples.comp_y = '0;
        samples.comp_z = '0;
        normals.ready  = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed extremes
        send_vector(32'd0, 32'd0, 32'd0);
        send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vector(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_vector(32'h8000_0000, 32'd0, 32'd0);
        send_vector(32'd0, 32'h7fff_ffff, 32'd0);
        send_vector(32'd0, 32'd0, 32'hffff_ffff);
        send_vector(32'd1, 32'd0, 32'd0);
        send_vector(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_vector(32'd1, 32'd1, 32'd1);
        send_vector(32'd3, 32'd4, 32'd0);
        send_vector(32'h0001_0000, 32'hffff_0000, 32'h0001_0000);
        send_vector(32'h8000_0000, 32'h7fff_ffff, 32'd1);
        send_vector(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
        send_vector(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
        send_vector(32'd2, 32'd3, 32'd6);
        drain();

        random_phase(400, 0, 0);
        random_phase(300, 52, 0);
        random_phase(300, 0, 52);
        random_phase(300, 17, 17);

        // long receiver hold so the pipeline fills and stalls input
        hold_normals = 1'b1;
        fork
            begin
                repeat (200) @(posedge clk);
                hold_normals = 1'b0;
            end
            random_phase(150, 0, 0);
        join
        drain();
        random_phase(100, 0, 0);
        drain();
        repeat (80) @(posedge clk);

        if (sb.pending() == 0 && sb.errors == 0)
            $display("vector_normalize_3d verification clean");
        else
            $display("vector_normalize_3d verification failed");
        $finish;
    end
endmodule

`default_nettype wire
